>>> src/sha_pkg.sv
// sha-256 stream hasher package: round constants, initial hash values and
// the command beat type shared by the front end and the compression engine
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  // action codes of an input beat
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

>>> src/sha256_stream_hasher.sv
// top level: command queue in front of the sha-256 compression engine
// depends on sha_pkg, sha_cmd_fifo, sha_engine
//
// usage
//   input queue: push with action/data_byte while full is low. action 0
//   absorbs a byte, action 1 finishes the message.
//   result queue: while empty is low digest_word/word_index/last show the
//   next digest word; pop takes it. a finish gives eight beats, H0 first.
//   flow: a pushed beat goes through the queue to the engine when idle;
//   the engine takes no beat while it pads, compresses or outputs. each
//   64th absorbed byte starts a compression: 64 rounds plus an add. a
//   finish writes the 0x80 marker, pads the rest of the block and
//   compresses it; at byte offset 56 or later it adds a length block.
//   then the eight output beats, one per cycle while pop is high.
//   a four-entry command queue lets the sender keep pushing while the
//   engine compresses; full rises when it fills.
//   reset loads the initial hash values and clears the byte count.
//   while the receiver holds off pop the digest beat holds and the engine
//   stops taking commands; the queue still takes up to four beats.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);
  sha_pkg::cmd_t in_cmd, q_cmd;
  logic q_empty, q_take;

  assign in_cmd.action    = action;
  assign in_cmd.data_byte = data_byte;

  sha_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_en(push), .wr_data(in_cmd), .full(full),
    .rd_en(q_take), .rd_data(q_cmd), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
    .digest_word(digest_word), .word_index(word_index), .last(last),
    .empty(empty), .pop(pop)
  );
endmodule
`default_nettype wire

>>> src/sha_cmd_fifo.sv
// short command queue between the input side and the compression engine
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire sha_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output sha_pkg::cmd_t      rd_data,
  output logic               empty
);
  sha_pkg::cmd_t slots [sha_pkg::QDEPTH];
  logic [sha_pkg::QAW-1:0] wr_ptr;
  logic [sha_pkg::QAW-1:0] rd_ptr;
  logic [sha_pkg::QAW:0]   count;

  assign full    = (count == (sha_pkg::QAW+1)'(sha_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (sha_pkg::QAW+1)'(wr_en && !full)
                     - (sha_pkg::QAW+1)'(rd_en && !empty);
    end
  end
endmodule
`default_nettype wire

>>> src/sha_engine.sv
// back end: block buffer, padding sequencer, 64-round compression and
// digest output register; depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire sha_pkg::cmd_t cmd,
  output logic               cmd_take,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last,
  output logic               empty,
  input  wire logic          pop
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [31:0] blk [16];  // block buffer, big-endian words
  logic [31:0] hw [8];
  logic [31:0] v [8];
  logic [31:0] wr [16];
  logic [60:0] byte_count;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic        fin;       // current compression is the last one of a finish
  logic        len_blk;   // padding pass writes the length
  logic [2:0]  oidx;
  logic        pad_pending;

  // schedule word and round function
  logic [3:0]  j;
  logic [31:0] wt, a1, a14, s0, s1, b1, ch, t1, b0, mj;
  logic [63:0] bits;
  always_comb begin
    j   = rnd[3:0];
    a1  = wr[j + 4'd1];
    a14 = wr[j + 4'd14];
    s0  = {a1[6:0], a1[31:7]} ^ {a1[17:0], a1[31:18]} ^ (a1 >> 3);
    s1  = {a14[16:0], a14[31:17]} ^ {a14[18:0], a14[31:19]} ^ (a14 >> 10);
    if (rnd[5:4] == 2'b00)
      wt = blk[rnd[3:0]];
    else
      wt = wr[j] + s0 + wr[j + 4'd9] + s1;
    b1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
       ^ {v[4][24:0], v[4][31:25]};
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + b1 + ch + sha_pkg::round_k(rnd) + wt;
    b0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
       ^ {v[0][21:0], v[0][31:22]};
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    bits = {byte_count, 3'd0};
  end

  assign cmd_take    = cmd_valid && (state == S_IDLE);
  assign empty       = (state != S_OUT);
  assign digest_word = hw[oidx];
  assign word_index  = oidx;
  assign last        = (oidx == 3'd7);

  // block buffer writes: absorb bytes, the finish marker and one padding byte per cycle
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      if (cmd.action == sha_pkg::ACT_ABSORB)
        blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= cmd.data_byte;
      else
        blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= 8'h80;
    end else if (state == S_PAD) begin
      if (len_blk && pos >= 6'd56)
        blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= bits[{~pos[2:0], 3'b000} +: 8];
      else
        blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= 8'h00;
    end
  end

  // round datapath
  always_ff @(posedge clk) begin
    if (state == S_RND) begin
      wr[j] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + b0 + mj;
    end else begin
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
    end
  end

  // finish in progress whose length block is still to come
  always_ff @(posedge clk) begin
    if (rst) pad_pending <= 1'b0;
    else if (cmd_take) pad_pending <= (cmd.action == sha_pkg::ACT_FINISH) && (pos >= 6'd56);
    else if (state == S_ADD) pad_pending <= 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      pos <= '0; rnd <= '0; fin <= 1'b0; len_blk <= 1'b0; oidx <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= sha_pkg::initial_h(3'(i));
    end else begin
      case (state)
        S_IDLE: if (cmd_take) begin
          pos <= pos + 6'd1;
          if (cmd.action == sha_pkg::ACT_ABSORB) begin
            byte_count <= byte_count + 61'd1;
            if (pos == 6'd63) begin
              fin <= 1'b0; rnd <= '0; state <= S_RND;
            end
          end else begin
            len_blk <= (pos < 6'd56);
            if (pos == 6'd63) begin
              fin <= 1'b0; rnd <= '0; state <= S_RND;
            end else state <= S_PAD;
          end
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            fin <= len_blk; rnd <= '0; state <= S_RND;
          end
        end
        S_RND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          if (fin) begin
            oidx <= '0; state <= S_OUT;
          end else if (pad_pending) begin
            // short tail: after the marker block, run a length block
            len_blk <= 1'b1; pos <= '0; state <= S_PAD;
          end else state <= S_IDLE;
        end
        S_OUT: if (pop) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            state <= S_IDLE;
            byte_count <= '0;
            pos <= '0;
            for (int i = 0; i < 8; i++) hw[i] <= sha_pkg::initial_h(3'(i));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/sha_checker.sv
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on sha256_stream_hasher
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last
);
  // last marks exactly the eighth word
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (word_index == 3'd7))) else $error("last mismatch");
  // a popped word is followed by the next index
  a_next: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && word_index == $past(word_index) + 3'd1))
    else $error("word order");
  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_index)))
    else $error("beat changed while stalled");
  // reset leaves no result
  a_rst: assert property (@(posedge clk) rst |=> empty) else $error("result after reset");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .digest_word(digest_word),
  .word_index(word_index), .last(last)
);
`default_nettype wire
